/* sv/mrem_pkg.sv */
// ============================================================================
// mrem_pkg
// Shared types and constants for the mixed relative error max-norm block.
// ============================================================================
package mrem_pkg;

    // Width of every coefficient part and of the result ratio.
    localparam int DATA_WIDTH = 32;
    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEFAULT = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // Register index, taken from paddr[2].
    localparam logic REG_ETA = 1'b0;
    localparam logic [DATA_WIDTH-1:0] ETA_RESET = DATA_WIDTH'(1);

    // One input word: a computed and a reference complex coefficient.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_real;
        logic signed [DATA_WIDTH-1:0] value_imag;
        logic signed [DATA_WIDTH-1:0] ref_real;
        logic signed [DATA_WIDTH-1:0] ref_imag;
        logic                         last;
    } in_word_t;

    // One output word: the norm of a set.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] max_error;
        logic                  saturated;
    } out_word_t;

    // Status of a magnitude unit.
    typedef struct packed {
        logic                  idle;
        logic                  done;
        logic [DATA_WIDTH-1:0] mag;
    } mag_res_t;

    // Status of the divider.
    typedef struct packed {
        logic                  idle;
        logic                  done;
        logic                  sat;
        logic [DATA_WIDTH-1:0] quo;
    } div_res_t;

endpackage

/* sv/mrem_mag.sv */
// ============================================================================
// mrem_mag
// Complex magnitude floor(sqrt(re^2 + im^2)), computed bit-serially: a
// shift-add sum of squares, then a restoring square root, one bit per cycle.
// ============================================================================
module mrem_mag
    import mrem_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         ack,
    input  logic signed [DATA_WIDTH-1:0] re,
    input  logic signed [DATA_WIDTH-1:0] im,
    output mag_res_t                     res
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [3:0] {
        MAG_IDLE = 4'b0001,
        MAG_SQ   = 4'b0010,
        MAG_RT   = 4'b0100,
        MAG_DONE = 4'b1000
    } mag_state_t;

    mag_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     mr_reg, mr_next;
    logic [W-1:0]     mi_reg, mi_next;
    logic [W-1:0]     br_reg, br_next;
    logic [W-1:0]     bi_reg, bi_next;
    logic [2*W-1:0]   acc_reg, acc_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     root_reg, root_next;

    logic [W-1:0]     abs_re, abs_im;
    logic [2*W-1:0]   acc_sq;
    logic [W+2:0]     rem_sh, trial, diff;
    logic             ge;

    // Magnitudes of the parts; the most negative value maps to 2^(W-1).
    assign abs_re = re[W-1] ? (~re + W'(1)) : re;
    assign abs_im = im[W-1] ? (~im + W'(1)) : im;

    // Sum of squares, multiplier bits taken most significant first.
    assign acc_sq = {acc_reg[2*W-2:0], 1'b0}
                  + (br_reg[W-1] ? (2*W)'(mr_reg) : '0)
                  + (bi_reg[W-1] ? (2*W)'(mi_reg) : '0);

    // Square root step: bring down two bits, try root*4+1.
    assign rem_sh = {rem_reg, acc_reg[2*W-1:2*W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mr_next    = mr_reg;
        mi_next    = mi_reg;
        br_next    = br_reg;
        bi_next    = bi_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (state_reg)
            MAG_IDLE:
            begin
                if (start)
                begin
                    mr_next    = abs_re;
                    br_next    = abs_re;
                    mi_next    = abs_im;
                    bi_next    = abs_im;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = MAG_SQ;
                end
            end
            MAG_SQ:
            begin
                acc_next = acc_sq;
                br_next  = {br_reg[W-2:0], 1'b0};
                bi_next  = {bi_reg[W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(W - 1);
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = MAG_RT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            MAG_RT:
            begin
                rem_next  = ge ? diff[W:0] : rem_sh[W:0];
                root_next = {root_reg[W-2:0], ge};
                acc_next  = {acc_reg[2*W-3:0], 2'b00};
                if (cnt_reg == '0)
                begin
                    state_next = MAG_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            MAG_DONE:
            begin
                if (ack)
                begin
                    state_next = MAG_IDLE;
                end
            end
            default:
            begin
                state_next = MAG_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAG_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mr_reg   <= mr_next;
        mi_reg   <= mi_next;
        br_reg   <= br_next;
        bi_reg   <= bi_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.idle = (state_reg == MAG_IDLE);
    assign res.done = (state_reg == MAG_DONE);
    assign res.mag  = root_reg;

endmodule

/* sv/mrem_div.sv */
// ============================================================================
// mrem_div
// Restoring divider for (num << FRAC_BITS) / den, one quotient bit per
// cycle, with saturation to the largest DATA_WIDTH-bit value.
// ============================================================================
module mrem_div
    import mrem_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  ack,
    input  logic [DATA_WIDTH-1:0] num,
    input  logic [DATA_WIDTH:0]   den,
    output div_res_t              res
);

    localparam int W     = DATA_WIDTH;
    localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    div_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [W:0]       den_reg, den_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     q_reg, q_next;
    logic             ovf_reg, ovf_next;

    logic [W+1:0]     rem_sh, diff;
    logic             ge;

    // Shift in the next numerator bit and try the divisor.
    assign rem_sh = {rem_reg, n_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});
    assign diff   = rem_sh - {1'b0, den_reg};

    // Sequencer. A quotient bit leaving the top of q_reg means overflow.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    n_next     = NUM_W'(num) << FRAC_BITS;
                    den_next   = den;
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                n_next   = {n_reg[NUM_W-2:0], 1'b0};
                rem_next = ge ? diff[W:0] : rem_sh[W:0];
                q_next   = {q_reg[W-2:0], ge};
                ovf_next = ovf_reg | q_reg[W-1];
                if (cnt_reg == '0)
                begin
                    state_next = DIV_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            DIV_DONE:
            begin
                if (ack)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign res.idle = (state_reg == DIV_IDLE);
    assign res.done = (state_reg == DIV_DONE);
    assign res.sat  = ovf_reg;
    assign res.quo  = ovf_reg ? '1 : q_reg;

endmodule

/* sv/mixed_relative_error_max_norm.sv */
// ============================================================================
// mixed_relative_error_max_norm
// Running maximum of |value| / (|reference| + eta) over a set of complex
// pairs, emitted on the word marked last.
// ============================================================================
//
//  Channel  Signals                                 Moves
//  -------  --------------------------------------  ------------------------
//  in       in_valid, in_ready, in_data             one coefficient pair
//  out      out_valid, out_ready, out_data          one norm per set
//  cfg      psel, penable, pwrite, paddr, pwdata,   eta register
//           prdata, pready
//
// A word passes through the two magnitude units (squaring, then square root,
// one bit per cycle), which take no new word until both are idle again; that
// loop sets the sustained rate. The divider works on one word while the
// magnitude units take the next.
// Reset clears the running maximum and the sticky flag and sets eta to 1.
// While an output word stalls, a divider result that ends a set is held,
// which in turn holds the magnitude units and then the input.
module mixed_relative_error_max_norm
    import mrem_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    mag_res_t v_res, r_res;
    div_res_t d_res;

    logic [DATA_WIDTH-1:0] eta_reg, eta_next;
    logic                  last1_reg, last1_next;
    logic                  last2_reg, last2_next;
    logic [DATA_WIDTH-1:0] max_reg, max_next;
    logic                  sticky_reg, sticky_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    logic                  accept, hand, fin, load, cfg_wr;
    logic [DATA_WIDTH:0]   den;
    logic [DATA_WIDTH-1:0] new_max;
    logic                  new_sat;

    // Input side: take a word when both magnitude units are free.
    assign in_ready = v_res.idle & r_res.idle;
    assign accept   = in_valid & in_ready;

    mrem_mag u_mag_value (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ack   (hand),
        .re    (in_data.value_real),
        .im    (in_data.value_imag),
        .res   (v_res)
    );

    mrem_mag u_mag_ref (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ack   (hand),
        .re    (in_data.ref_real),
        .im    (in_data.ref_imag),
        .res   (r_res)
    );

    // Hand both magnitudes to the divider once it is free.
    assign hand = v_res.done & r_res.done & d_res.idle;
    assign den  = {1'b0, r_res.mag} + {1'b0, eta_reg};

    mrem_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hand),
        .ack   (fin),
        .num   (v_res.mag),
        .den   (den),
        .res   (d_res)
    );

    // Retire a ratio; a last word also needs room in the output register.
    assign fin     = d_res.done & (~last2_reg | ~out_valid_reg | out_ready);
    assign load    = fin & last2_reg;
    assign new_max = (d_res.quo > max_reg) ? d_res.quo : max_reg;
    assign new_sat = sticky_reg | d_res.sat;

    // Configuration write.
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        eta_next       = eta_reg;
        last1_next     = last1_reg;
        last2_next     = last2_reg;
        max_next       = max_reg;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cfg_wr && (paddr[2] == REG_ETA))
        begin
            eta_next = pwdata[DATA_WIDTH-1:0];
        end
        if (accept)
        begin
            last1_next = in_data.last;
        end
        if (hand)
        begin
            last2_next = last1_reg;
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fin)
        begin
            if (last2_reg)
            begin
                out_data_next.max_error = new_max;
                out_data_next.saturated = new_sat;
                out_valid_next          = 1'b1;
                max_next                = '0;
                sticky_next             = 1'b0;
            end
            else
            begin
                max_next    = new_max;
                sticky_next = new_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg       <= ETA_RESET;
            last1_reg     <= 1'b0;
            last2_reg     <= 1'b0;
            max_reg       <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eta_reg       <= eta_next;
            last1_reg     <= last1_next;
            last2_reg     <= last2_next;
            max_reg       <= max_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register, loaded only when the result is final.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Register read-back; addresses with paddr[2] set read as zero.
    assign prdata = (paddr[2] == REG_ETA) ? APB_DATA_W'(eta_reg) : '0;
    assign pready = 1'b1;

endmodule

/* sv/mrem_checker.sv */
// ============================================================================
// mrem_checker
// Port-level checks for the max-norm block, bound to its top level.
// ============================================================================
module mrem_checker
    import mrem_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_word_t             out_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A stalled output word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

    // The magnitude units take one pair at a time: busy right after a take.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the magnitudes were done");

    // A clipped set reports the largest value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.max_error == '1)
    else $error("saturated flag set without a saturated maximum");

    // A written eta reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_ETA)
        |=> (paddr[2] != REG_ETA) || (prdata == $past(pwdata)))
    else $error("eta read-back differs from the last write");

endmodule

bind mixed_relative_error_max_norm mrem_checker u_mrem_checker (.*);

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the mixed relative error max-norm block.
//
// Coefficient pairs go in over a valid/ready channel in bursts with random
// gaps, and the norm words come out under a changing backpressure pattern.
// Each accepted pair feeds a local predictor of the running maximum ratio.
// Every set that ends on a last pair leaves one expected norm word. Each
// output word is checked field by field against the oldest expected word.
// The eta register is rewritten over APB between phases, and eta is read
// back after each write. The run starts with a directed part, then moves on to
// random sets under several eta values, zero and all ones among them.
// ============================================================================
module tb_top
    import mrem_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 160;
    localparam logic [APB_ADDR_W-1:0] ETA_ADDR = {REG_ETA, 2'b00};
    // The second register slot decodes to nothing.
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_ETA, 2'b00};
    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Pending input words and the norm words that the predictor expects.
    in_word_t pair_q[$];
    out_word_t norm_q[$];
    out_word_t norm_want;

    // Predictor state.
    logic [DATA_WIDTH-1:0] eta_model = ETA_RESET;
    logic [DATA_WIDTH-1:0] set_max = '0;
    logic set_clipped = 1'b0;

    int unsigned pairs_queued = 0;
    int unsigned pairs_taken = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    logic in_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_window = 0;
    logic [15:0] ready_mask = '1;

    mixed_relative_error_max_norm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Absolute value of a two's complement part; the most negative value
    // maps to its exact magnitude.
    function automatic logic [DATA_WIDTH-1:0] part_abs(logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // Floor of the complex magnitude, found bit by bit from the top.
    function automatic logic [DATA_WIDTH-1:0] complex_abs(logic [DATA_WIDTH-1:0] re,
                                                          logic [DATA_WIDTH-1:0] im);
        logic [63:0] ar;
        logic [63:0] ai;
        logic [63:0] power;
        logic [63:0] trial;
        logic [DATA_WIDTH-1:0] root;
        ar = 64'(part_abs(re));
        ai = 64'(part_abs(im));
        power = ar * ar + ai * ai;
        root = '0;
        for (int b = DATA_WIDTH - 1; b >= 0; b--)
        begin
            trial = 64'(root | (DATA_WIDTH'(1) << b));
            if (trial * trial <= power)
                root = trial[DATA_WIDTH-1:0];
        end
        return root;
    endfunction

    // Clip flag and ratio of one pair; a zero divisor gives all ones.
    function automatic logic [DATA_WIDTH:0] pair_ratio(in_word_t w, logic [DATA_WIDTH-1:0] eta);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(complex_abs(w.value_real, w.value_imag)) << FRAC_BITS_DEFAULT;
        den = 64'(complex_abs(w.ref_real, w.ref_imag)) + 64'(eta);
        if (den == '0)
            return {1'b1, ALL_ONES};
        quo = num / den;
        if (quo[63:DATA_WIDTH] != '0)
            return {1'b1, ALL_ONES};
        return {1'b0, quo[DATA_WIDTH-1:0]};
    endfunction

    // Fold one accepted word into the running maximum of its set.
    task automatic account_pair(in_word_t w);
        logic [DATA_WIDTH:0] r;
        out_word_t norm;
        r = pair_ratio(w, eta_model);
        if (r[DATA_WIDTH])
            set_clipped = 1'b1;
        if (r[DATA_WIDTH-1:0] > set_max)
            set_max = r[DATA_WIDTH-1:0];
        if (w.last)
        begin
            norm.max_error = set_max;
            norm.saturated = set_clipped;
            norm_q.push_back(norm);
            set_max = '0;
            set_clipped = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Input acceptance and output checking.
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pairs_taken++;
                account_pair(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (norm_q.size() == 0)
                    report_mismatch("word with none expected", '0, out_data.max_error);
                else
                begin
                    norm_want = norm_q.pop_front();
                    if (out_data.max_error !== norm_want.max_error)
                        report_mismatch("max_error", norm_want.max_error, out_data.max_error);
                    if (out_data.saturated !== norm_want.saturated)
                        report_mismatch("saturated", 32'(norm_want.saturated),
                                        32'(out_data.saturated));
                end
            end
        end
    end

    // Input driver: bursts of words with random gaps between them.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pair_q.size() != 0)
            begin
                in_data <= pair_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                            : $urandom_range(0, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output backpressure: a rotating mask, redrawn when its stall window runs out.
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_window = $urandom_range(40, 120);
            case ($urandom_range(0, 5))
                0, 1: ready_mask = '1;
                2: ready_mask = '0;
                default: ready_mask = 16'($urandom());
            endcase
        end
        stall_window--;
        ready_mask = {ready_mask[0], ready_mask[15:1]};
        out_ready <= ready_mask[0];
    end

    task automatic add_pair(logic [DATA_WIDTH-1:0] vr, logic [DATA_WIDTH-1:0] vi,
                            logic [DATA_WIDTH-1:0] rr, logic [DATA_WIDTH-1:0] ri,
                            logic last);
        in_word_t w;
        w.value_real = vr;
        w.value_imag = vi;
        w.ref_real = rr;
        w.ref_imag = ri;
        w.last = last;
        pair_q.push_back(w);
        pairs_queued++;
    endtask

    // Wait until every word is in and every norm is out, then let the
    // divider run dry.
    task automatic settle();
        while (pairs_taken != pairs_queued || norm_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write followed by a read back of eta.
    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] got;
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr[2] == REG_ETA)
            eta_model = data;
        psel = 1'b1;
        paddr = ETA_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== eta_model)
            report_mismatch("eta read back", eta_model, got);
    endtask

    // One random coefficient part, from full range down to tiny values.
    function automatic logic [DATA_WIDTH-1:0] random_part();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0, 1: return r;
            2: return {{12{r[19]}}, r[19:0]};
            3: return {{24{r[7]}}, r[7:0]};
            4:
            begin
                case (r[1:0])
                    2'd0: return MOST_NEG;
                    2'd1: return MOST_POS;
                    2'd2: return '0;
                    default: return ALL_ONES;
                endcase
            end
            default: return {{6{r[25]}}, r[25:0]};
        endcase
    endfunction

    // Random sets, each closed by a last word; some values track their
    // reference so that ratios stay near one.
    task automatic add_random_sets(int unsigned count);
        int unsigned done;
        int unsigned len;
        logic [DATA_WIDTH-1:0] rr;
        logic [DATA_WIDTH-1:0] ri;
        logic [DATA_WIDTH-1:0] vr;
        logic [DATA_WIDTH-1:0] vi;
        done = 0;
        while (done < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                rr = random_part();
                ri = random_part();
                if ($urandom_range(0, 15) == 0)
                begin
                    rr = '0;
                    ri = '0;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    vr = rr + DATA_WIDTH'($signed($urandom_range(0, 511)) - 256);
                    vi = ri + DATA_WIDTH'($signed($urandom_range(0, 511)) - 256);
                end
                else
                begin
                    vr = random_part();
                    vi = random_part();
                end
                add_pair(vr, vi, rr, ri, k == len - 1);
            end
            done += len;
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset value of eta.
        add_pair('0, '0, '0, '0, 1'b1);
        add_pair(MOST_NEG, MOST_NEG, '0, '0, 1'b1);
        add_pair(MOST_POS, '0, MOST_NEG, MOST_NEG, 1'b1);
        add_pair(32'h0001_0000, '0, 32'h0001_0000, '0, 1'b1);
        add_pair(32'h0003_0000, 32'h0004_0000, '0, 32'h0001_0000, 1'b0);
        add_pair(32'd1, '0, MOST_POS, MOST_POS, 1'b0);
        add_pair(ALL_ONES, ALL_ONES, ALL_ONES, '0, 1'b1);
        add_pair(MOST_POS, MOST_POS, MOST_NEG, '0, 1'b1);
        // A clipped word early in a set keeps the flag to the end.
        add_pair(MOST_POS, '0, '0, '0, 1'b0);
        add_pair('0, '0, 32'd5, 32'd5, 1'b1);
        settle();

        // Largest eta.
        write_reg(ETA_ADDR, ALL_ONES);
        add_pair(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 1'b1);
        add_pair(MOST_POS, '0, '0, '0, 1'b1);
        add_pair('0, '0, '0, '0, 1'b1);
        settle();

        // Zero eta: a zero reference leaves the divider with nothing.
        write_reg(ETA_ADDR, '0);
        add_pair('0, '0, '0, '0, 1'b1);
        add_pair(32'd3, 32'hFFFF_FFFD, '0, '0, 1'b1);
        add_pair(32'h0001_0000, '0, '0, 32'h0002_0000, 1'b1);
        settle();

        // A write to the unused slot must leave eta alone.
        write_reg(SPARE_ADDR, 32'h1234_5678);
        add_pair('0, '0, '0, '0, 1'b1);
        settle();

        // Random sets under a range of eta settings.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: write_reg(ETA_ADDR, 32'd1);
                1: write_reg(ETA_ADDR, ALL_ONES);
                2: write_reg(ETA_ADDR, 32'h0001_0000);
                3: write_reg(ETA_ADDR, $urandom());
                4: write_reg(ETA_ADDR, $urandom_range(1, 32'hFFFF));
                5: write_reg(ETA_ADDR, '0);
                6: write_reg(ETA_ADDR, $urandom_range(32'h1_0000, 32'h100_0000));
                default: write_reg(ETA_ADDR, ETA_RESET);
            endcase
            add_random_sets(212);
            settle();
        end

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
sv/mrem_pkg.sv
sv/mrem_mag.sv
sv/mrem_div.sv
sv/mixed_relative_error_max_norm.sv
sv/mrem_checker.sv
tb/tb_top.sv
